// ===== hdl/sle_pkg.sv =====
// Package with the request and status codes and the cell control type of the sorted list engine.
package sle_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_POP    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic        cmp_en;
    logic        ins;
    logic        del;
    logic        pop;
    logic [31:0] value;
  } cell_ctrl_t;

endpackage

// ===== hdl/sle_if.sv =====
// Request and response channel interfaces of the sorted list engine.
interface sle_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

interface sle_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] popped_value;
  logic [4:0]  entry_count;

  modport source (output valid, output status, output popped_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input popped_value, input entry_count,
                output ready);
endinterface

// ===== hdl/sorted_list_engine_unit.sv =====
// Top level of the sorted list engine: a chain of compare and shift cells with a sequencer.
// A request beat is answered in two steps: the accepting edge registers the compare of the
// operand against every cell, then the apply step updates the chain and loads the response
// register. The next request is accepted after the apply step, which waits while the previous
// response beat is still held. Reset empties the list; entry contents stay undefined.
module sorted_list_engine_unit #(
  parameter int DEPTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  sle_req_if.sink   req_i,
  sle_rsp_if.source rsp_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'b01,
    FSM_APPLY = 2'b10
  } fsm_e;

  fsm_e                fsm_q, fsm_d;
  logic [CntW-1:0]     count_q, count_d;
  sle_pkg::req_type_e  req_q;
  logic [31:0]         value_q;
  logic                rsp_valid_q, rsp_valid_d;
  sle_pkg::status_e    status_q, status_d;
  logic [31:0]         popped_q, popped_d;
  logic [CntW+4:0]     count_ext;

  logic [31:0]         cell_value [DEPTH];
  logic [DEPTH-1:0]    cell_lt;
  logic [DEPTH-1:0]    cell_eq;
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    hit;
  sle_pkg::cell_ctrl_t ctrl;

  logic accept;
  logic apply;
  logic found;
  logic full;
  logic empty;

  assign req_i.ready = (fsm_q == FSM_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign apply       = (fsm_q == FSM_APPLY) && (!rsp_valid_q || rsp_o.ready);
  assign full        = (count_q == CntW'(DEPTH));
  assign empty       = (count_q == '0);
  assign found       = |hit;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_valid[i] = (CntW'(i) < count_q);
      if (i == 0) begin
        hit[i] = cell_eq[i];
      end else begin
        hit[i] = cell_eq[i] && cell_lt[i-1];
      end
    end
  end

  always_comb begin
    ctrl.cmp_en = accept;
    ctrl.value  = accept ? req_i.value : value_q;
    ctrl.ins    = apply && (req_q == sle_pkg::REQ_INSERT) && !full;
    ctrl.del    = apply && (req_q == sle_pkg::REQ_DELETE) && found;
    ctrl.pop    = apply && (req_q == sle_pkg::REQ_POP) && !empty;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [31:0] left_value;
    logic        left_lt;
    logic [31:0] right_value;
    if (g == 0) begin : g_first
      assign left_value = cell_value[g];
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_value = cell_value[g-1];
      assign left_lt    = cell_lt[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_value = cell_value[g];
    end else begin : g_body
      assign right_value = cell_value[g+1];
    end
    sle_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (cell_valid[g]),
      .left_value_i  (left_value),
      .left_lt_i     (left_lt),
      .right_value_i (right_value),
      .value_o       (cell_value[g]),
      .lt_o          (cell_lt[g]),
      .eq_o          (cell_eq[g])
    );
  end

  always_comb begin
    fsm_d       = fsm_q;
    count_d     = count_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    status_d    = status_q;
    popped_d    = popped_q;
    unique case (fsm_q)
      FSM_IDLE: begin
        if (accept) begin
          fsm_d = FSM_APPLY;
        end
      end
      FSM_APPLY: begin
        if (apply) begin
          fsm_d       = FSM_IDLE;
          rsp_valid_d = 1'b1;
          status_d    = sle_pkg::ST_DONE;
          popped_d    = '0;
          unique case (req_q)
            sle_pkg::REQ_INSERT: begin
              if (full) begin
                status_d = sle_pkg::ST_FULL;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            sle_pkg::REQ_SEARCH: begin
              if (!found) begin
                status_d = sle_pkg::ST_NOT_FOUND;
              end
            end
            sle_pkg::REQ_DELETE: begin
              if (!found) begin
                status_d = sle_pkg::ST_NOT_FOUND;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            sle_pkg::REQ_POP: begin
              if (empty) begin
                status_d = sle_pkg::ST_EMPTY;
              end else begin
                popped_d = cell_value[0];
                count_d  = count_q - 1'b1;
              end
            end
            default: begin
              status_d = sle_pkg::ST_DONE;
            end
          endcase
        end
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= sle_pkg::req_type_e'(req_i.req_type);
      value_q <= req_i.value;
    end
    status_q <= status_d;
    popped_q <= popped_d;
  end

  assign count_ext          = {5'd0, count_q};
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.popped_value = popped_q;
  assign rsp_o.entry_count  = count_ext[4:0];

endmodule

// ===== hdl/sle_cell.sv =====
// One cell of the sorted chain: holds an entry, compares it and shifts with its neighbors.
module sle_cell (
  input  logic                clk_i,
  input  sle_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic [31:0]         left_value_i,
  input  logic                left_lt_i,
  input  logic [31:0]         right_value_i,
  output logic [31:0]         value_o,
  output logic                lt_o,
  output logic                eq_o
);

  logic [31:0] value_q;
  logic [31:0] value_d;
  logic        lt_q;
  logic        eq_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins && !lt_q) begin
      value_d = left_lt_i ? ctrl_i.value : left_value_i;
    end else if (ctrl_i.pop || (ctrl_i.del && !lt_q)) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (ctrl_i.cmp_en) begin
      lt_q <= valid_i && ($signed(value_q) < $signed(ctrl_i.value));
      eq_q <= valid_i && (value_q == ctrl_i.value);
    end
  end

  assign value_o = value_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

// ===== dv/sle_result_check.sv =====
`timescale 1ns / 100ps
// Checker of the sorted list engine: watches both channels, predicts each response and compares it.
module sle_result_check #(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sle_req_if        req_mon,
  sle_rsp_if        rsp_mon,
  output int        fail_count_o,
  output int        outstanding_o
);

  typedef struct packed {
    sle_pkg::status_e status;
    logic [31:0]      popped;
    logic [4:0]       count;
  } sle_result_t;

  logic signed [31:0] sorted_q[$];
  sle_result_t        expected_q[$];
  sle_result_t        head;
  int                 mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t sle_result_check: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic sle_result_t apply_request(input sle_pkg::req_type_e kind,
                                                input logic signed [31:0] operand);
    sle_result_t res;
    int          pos;
    res.status = sle_pkg::ST_DONE;
    res.popped = '0;
    pos = 0;
    case (kind)
      sle_pkg::REQ_INSERT: begin
        if (sorted_q.size() >= DEPTH) begin
          res.status = sle_pkg::ST_FULL;
        end else begin
          while (pos < sorted_q.size() && sorted_q[pos] < operand) pos++;
          sorted_q.insert(pos, operand);
        end
      end
      sle_pkg::REQ_SEARCH, sle_pkg::REQ_DELETE: begin
        while (pos < sorted_q.size() && sorted_q[pos] != operand) pos++;
        if (pos >= sorted_q.size()) begin
          res.status = sle_pkg::ST_NOT_FOUND;
        end else if (kind == sle_pkg::REQ_DELETE) begin
          sorted_q.delete(pos);
        end
      end
      default: begin
        if (sorted_q.size() == 0) begin
          res.status = sle_pkg::ST_EMPTY;
        end else begin
          res.popped = sorted_q.pop_front();
        end
      end
    endcase
    res.count = 5'(sorted_q.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_q.delete();
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_q.size() == 0) begin
          note_mismatch("response beat with nothing outstanding, status", 32'(rsp_mon.status),
                        '0);
        end else begin
          head = expected_q.pop_front();
          if (rsp_mon.status !== head.status) begin
            note_mismatch("status", 32'(rsp_mon.status), 32'(head.status));
          end
          if (rsp_mon.popped_value !== head.popped) begin
            note_mismatch("popped_value", rsp_mon.popped_value, head.popped);
          end
          if (rsp_mon.entry_count !== head.count) begin
            note_mismatch("entry_count", 32'(rsp_mon.entry_count), 32'(head.count));
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_q.push_back(apply_request(sle_pkg::req_type_e'(req_mon.req_type),
                                           req_mon.value));
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the sorted list engine: clock, reset, request and response traffic, verdict.
module tb;

  localparam int DEPTH = 16;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rsp_steady;
  logic rsp_hold_req;
  bit   gaps_on;
  int   fail_count;
  int   outstanding;

  sle_req_if req_if ();
  sle_rsp_if rsp_if ();

  sorted_list_engine_unit #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sle_result_check #(.DEPTH(DEPTH)) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_if),
    .rsp_mon       (rsp_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic send_req(input sle_pkg::req_type_e kind, input logic [31:0] operand);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= operand;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic sle_pkg::req_type_e pick_kind(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 70) return sle_pkg::REQ_INSERT;
        else if (r < 80) return sle_pkg::REQ_SEARCH;
        else if (r < 90) return sle_pkg::REQ_DELETE;
        else return sle_pkg::REQ_POP;
      end
      1: return sle_pkg::req_type_e'(2'($urandom_range(0, 3)));
      default: begin
        if (r < 15) return sle_pkg::REQ_INSERT;
        else if (r < 30) return sle_pkg::REQ_SEARCH;
        else if (r < 60) return sle_pkg::REQ_DELETE;
        else return sle_pkg::REQ_POP;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($urandom_range(0, 8)) - 32'd4;
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (rsp_hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 79;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= rsp_steady || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  initial begin
    int phase;
    int n;
    req_if.valid    <= 1'b0;
    req_if.req_type <= sle_pkg::REQ_INSERT;
    req_if.value    <= '0;
    rst_ni          <= 1'b0;
    rsp_steady      <= 1'b0;
    rsp_hold_req    <= 1'b0;
    gaps_on = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(sle_pkg::REQ_POP, 32'h1234_5678);
    send_req(sle_pkg::REQ_DELETE, '0);
    send_req(sle_pkg::REQ_INSERT, 32'h8000_0000);
    send_req(sle_pkg::REQ_INSERT, 32'h7FFF_FFFF);
    send_req(sle_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_req(sle_pkg::REQ_INSERT, '0);
    send_req(sle_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_req(sle_pkg::REQ_SEARCH, 32'hFFFF_FFFF);
    send_req(sle_pkg::REQ_SEARCH, 32'd7);
    send_req(sle_pkg::REQ_DELETE, 32'd7);
    send_req(sle_pkg::REQ_DELETE, 32'hFFFF_FFFF);
    send_req(sle_pkg::REQ_POP, 32'hEDCB_A987);
    for (n = 0; n < 14; n++) begin
      send_req(sle_pkg::REQ_INSERT,
               n[0] ? (32'h5555_5555 ^ 32'(n)) : (32'hAAAA_AAAA ^ 32'(n)));
    end

    for (phase = 0; phase < 13; phase++) begin
      if (phase == 3) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end
      gaps_on = (phase != 7);
      rsp_steady <= (phase == 7);
      if (phase == 5) rsp_hold_req <= 1'b1;
      for (n = 0; n < 80; n++) begin
        send_req(pick_kind(phase % 3), pick_operand());
      end
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
